// ----- rtl/gbsp_pkg.sv -----
// shared types and constants of the grid breadth-first search block
`timescale 1ns / 1ps
`default_nettype none
package gbsp_pkg;

	localparam int CFG_W        = 9;
	localparam int AREA_W       = 2 * CFG_W;
	localparam int DIST_W       = 16;
	localparam int DEF_MAX_ROWS = 256;
	localparam int DEF_MAX_COLS = 256;

	typedef enum logic [1:0] {
		KIND_OPEN  = 2'd0,
		KIND_WALL  = 2'd1,
		KIND_START = 2'd2,
		KIND_END   = 2'd3
	} cell_kind_t;

	typedef enum logic [0:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cell_kind_t cell_kind;
		logic       last_cell;
	} cell_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              unreachable;
	} result_item_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic             done;
		logic [CFG_W-1:0] quot;
		logic [CFG_W-1:0] rem;
	} div_res_t;

endpackage
`default_nettype wire

// ----- rtl/gbsp_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module gbsp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/gbsp_div.sv -----
// restoring divider, one quotient bit per cycle, splits a raster index into row and column
`timescale 1ns / 1ps
`default_nettype none
module gbsp_div #(
	parameter int DW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              dividend,
	input  logic [gbsp_pkg::CFG_W-1:0] divisor,
	output gbsp_pkg::div_res_t         res
);
	import gbsp_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]    quot_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   diff;
	logic             take;

	assign trial = {rem_q, quot_q[DW-1]};
	assign take  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= take ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
			quot_q <= {quot_q[DW-2:0], take};
		end
	end

	assign res = '{done: done_q, quot: CFG_W'(quot_q), rem: rem_q};

endmodule
`default_nettype wire

// ----- rtl/grid_bfs_shortest_path.sv -----
// top level: grid loader, breadth-first search sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
// Shortest four-neighbour path on a grid streamed one cell per item in raster order.
// Set grid_rows and grid_cols (0 acts as 1, values above MAX_ROWS or MAX_COLS clamp)
// while the block is idle, then stream the cells; the item with last_cell set starts
// the search and yields one result: the step count from the last start marker to the
// last end marker, or unreachable (distance 0) when a marker is missing, lies outside
// the grid, equals the other marker or cannot be reached. Cells go in one per cycle
// while the block loads. After the last cell the block stalls its input through
// setup (marker check and a bit-serial row/column split of the start index), then
// for each cell taken off the frontier queue a queue read, a fetch and four
// neighbour probes through the cell memory plus one drain step, then a walk over
// the queued cells to wipe the visited bits, then a hand-over of the result to the
// output register; a grid with a missing or outside marker goes from the check
// straight to the result. The search time is set by the single read port of the
// cell memory, probed one neighbour per cycle. A finished result waits in the
// output register while the next grid loads. After reset the block clears the
// wall and visited bits of every cell with its input stalled; configuration writes
// are taken throughout.
module grid_bfs_shortest_path #(
	parameter int MAX_ROWS = gbsp_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gbsp_pkg::DEF_MAX_COLS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  gbsp_pkg::cfg_reg_t         cfg_index,
	input  logic [gbsp_pkg::CFG_W-1:0] cfg_data,
	input  logic                       cell_valid,
	output logic                       cell_stall,
	input  gbsp_pkg::cell_item_t       cell_item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output gbsp_pkg::result_item_t     result
);
	import gbsp_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int POS_W = AW + 1;
	localparam int CMP_W = (POS_W > AREA_W) ? POS_W : AREA_W;

	// neighbour order: up, right, down, left; the extra step drains the probe stage
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;
	localparam logic [2:0] K_DRAIN   = 3'd4;

	// frontier entry: raster index plus its row and column, so no division per cell
	typedef struct packed {
		logic [AW-1:0]    lin;
		logic [CFG_W-1:0] row;
		logic [CFG_W-1:0] col;
	} qent_t;

	typedef struct packed {
		logic wall;
		logic visited;
	} cell_entry_t;

	typedef enum logic [8:0] {
		ST_INIT   = 9'b000000001,
		ST_LOAD   = 9'b000000010,
		ST_CHECK  = 9'b000000100,
		ST_DIV    = 9'b000001000,
		ST_POP    = 9'b000010000,
		ST_FETCH  = 9'b000100000,
		ST_PROBE  = 9'b001000000,
		ST_UNWIND = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_W-1:0]  rows_q;
	logic [CFG_W-1:0]  cols_q;
	logic [CFG_W-1:0]  eff_rows;
	logic [CFG_W-1:0]  eff_cols;
	logic [AREA_W-1:0] area;

	// grid loading
	logic [AW-1:0]    clr_q;
	logic [POS_W-1:0] load_pos_q;
	logic             start_pres_q;
	logic             end_pres_q;
	logic [AW-1:0]    start_pos_q;
	logic [AW-1:0]    end_pos_q;
	logic             cell_acc;
	logic             in_grid;
	logic             bad_markers;

	// search
	logic [POS_W-1:0]  head_q;
	logic [POS_W-1:0]  tail_q;
	logic [POS_W-1:0]  lvl_end_q;
	logic [POS_W-1:0]  unw_q;
	logic [DIST_W-1:0] lvl_q;
	logic [DIST_W-1:0] child_lvl;
	logic [DIST_W-1:0] dist_q;
	logic [2:0]        k_q;
	logic              found_q;
	qent_t             here_q;
	qent_t             nb_ent;
	logic              nb_inb;
	logic              nb_issue;
	logic              nb_vld_s1;
	qent_t             nb_ent_s1;
	logic              nb_free;
	logic              nb_hit;
	logic              unw_vld_s1;
	qent_t             seed_ent;

	// memories
	logic        cell_we;
	logic [AW-1:0] cell_waddr;
	cell_entry_t cell_wdata;
	logic [AW-1:0] cell_raddr;
	cell_entry_t cell_rd;
	logic        q_we;
	logic [AW-1:0] q_waddr;
	qent_t       q_wdata;
	logic [AW-1:0] q_raddr;
	qent_t       q_rdata;

	// divider
	logic     div_start;
	div_res_t div_res;

	// output register
	logic         res_valid_q;
	result_item_t result_q;
	logic         res_load;

	assign cfg_ready    = 1'b1;
	assign cell_stall   = (state_q != ST_LOAD);
	assign result_valid = res_valid_q;
	assign result       = result_q;
	assign cell_acc     = cell_valid && !cell_stall;
	assign res_load     = (state_q == ST_DONE) && (!res_valid_q || !result_stall);

	// effective grid size: zero acts as one, large counts clamp to the maximum
	always_comb begin
		if (rows_q == '0) begin
			eff_rows = CFG_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			eff_rows = CFG_W'(MAX_ROWS);
		end else begin
			eff_rows = rows_q;
		end
		if (cols_q == '0) begin
			eff_cols = CFG_W'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			eff_cols = CFG_W'(MAX_COLS);
		end else begin
			eff_cols = cols_q;
		end
	end

	assign area    = AREA_W'(eff_rows) * AREA_W'(eff_cols);
	assign in_grid = CMP_W'(load_pos_q) < CMP_W'(area);

	// markers missing or outside the grid as configured now
	assign bad_markers = !start_pres_q || !end_pres_q
		|| (CMP_W'(start_pos_q) >= CMP_W'(area))
		|| (CMP_W'(end_pos_q) >= CMP_W'(area));

	assign div_start = (state_q == ST_CHECK) && !bad_markers;
	assign seed_ent  = '{lin: start_pos_q, row: div_res.quot, col: div_res.rem};

	// distance of the children of the current cell, saturating
	assign child_lvl = (lvl_q == '1) ? lvl_q : lvl_q + DIST_W'(1);

	// neighbour k of the current cell; index moves by one column or one row
	always_comb begin
		nb_ent = here_q;
		nb_inb = 1'b0;
		unique case (k_q[1:0])
			DIR_UP: begin
				nb_inb     = here_q.row != '0;
				nb_ent.row = here_q.row - CFG_W'(1);
				nb_ent.lin = here_q.lin - AW'(eff_cols);
			end
			DIR_RIGHT: begin
				nb_inb     = ({1'b0, here_q.col} + (CFG_W + 1)'(1)) < {1'b0, eff_cols};
				nb_ent.col = here_q.col + CFG_W'(1);
				nb_ent.lin = here_q.lin + AW'(1);
			end
			DIR_DOWN: begin
				nb_inb     = ({1'b0, here_q.row} + (CFG_W + 1)'(1)) < {1'b0, eff_rows};
				nb_ent.row = here_q.row + CFG_W'(1);
				nb_ent.lin = here_q.lin + AW'(eff_cols);
			end
			DIR_LEFT: begin
				nb_inb     = here_q.col != '0;
				nb_ent.col = here_q.col - CFG_W'(1);
				nb_ent.lin = here_q.lin - AW'(1);
			end
			default: begin
				nb_inb = 1'b0;
			end
		endcase
	end

	assign nb_issue = (state_q == ST_PROBE) && (k_q != K_DRAIN) && nb_inb;

	// probe result in the cycle after the read: open and not yet seen
	assign nb_free = nb_vld_s1 && !cell_rd.wall && !cell_rd.visited;
	assign nb_hit  = nb_free && (nb_ent_s1.lin == end_pos_q);

	// memory port steering, one user per state
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = nb_ent_s1.lin;
		cell_wdata = '{wall: 1'b0, visited: 1'b1};
		cell_raddr = nb_ent.lin;
		q_we       = 1'b0;
		q_waddr    = tail_q[AW-1:0];
		q_wdata    = nb_ent_s1;
		q_raddr    = head_q[AW-1:0];
		unique case (state_q)
			ST_INIT: begin
				cell_we    = 1'b1;
				cell_waddr = clr_q;
				cell_wdata = '{wall: 1'b0, visited: 1'b0};
			end
			ST_LOAD: begin
				// visited bits are already clear between grids
				if (cell_acc && in_grid) begin
					cell_we    = 1'b1;
					cell_waddr = load_pos_q[AW-1:0];
					cell_wdata = '{wall: cell_item.cell_kind == KIND_WALL, visited: 1'b0};
				end
			end
			ST_DIV: begin
				// seed the search with the start cell
				if (div_res.done) begin
					cell_we    = 1'b1;
					cell_waddr = start_pos_q;
					q_we       = 1'b1;
					q_waddr    = '0;
					q_wdata    = seed_ent;
				end
			end
			ST_PROBE: begin
				// the end cell is never queued, so it needs no mark
				if (nb_free && !nb_hit) begin
					cell_we = 1'b1;
					q_we    = 1'b1;
				end
			end
			ST_UNWIND: begin
				// every marked cell sits in the queue: walk it and wipe the marks
				q_raddr = unw_q[AW-1:0];
				if (unw_vld_s1) begin
					cell_we    = 1'b1;
					cell_waddr = q_rdata.lin;
					cell_wdata = '{wall: 1'b0, visited: 1'b0};
				end
			end
			ST_CHECK, ST_POP, ST_FETCH, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			rows_q       <= CFG_W'(1);
			cols_q       <= CFG_W'(1);
			clr_q        <= '0;
			load_pos_q   <= '0;
			start_pres_q <= 1'b0;
			end_pres_q   <= 1'b0;
			start_pos_q  <= '0;
			end_pos_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			lvl_end_q    <= '0;
			unw_q        <= '0;
			lvl_q        <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			nb_vld_s1    <= 1'b0;
			unw_vld_s1   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GRID_ROWS: rows_q <= cfg_data;
					REG_GRID_COLS: cols_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// a new result may replace the one leaving in the same cycle
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_valid && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			// a hit ends the probes, so the read issued with it is dropped
			nb_vld_s1  <= nb_issue && !nb_hit;
			unw_vld_s1 <= (state_q == ST_UNWIND) && (unw_q != tail_q);

			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cell_acc) begin
						// cells past the grid are dropped, their last flag still counts
						if (in_grid) begin
							load_pos_q <= load_pos_q + POS_W'(1);
							if (cell_item.cell_kind == KIND_START) begin
								start_pres_q <= 1'b1;
								start_pos_q  <= load_pos_q[AW-1:0];
							end else if (cell_item.cell_kind == KIND_END) begin
								end_pres_q <= 1'b1;
								end_pos_q  <= load_pos_q[AW-1:0];
							end
						end
						if (cell_item.last_cell) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					state_q <= bad_markers ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						head_q    <= '0;
						tail_q    <= POS_W'(1);
						lvl_q     <= '0;
						lvl_end_q <= POS_W'(1);
						state_q   <= ST_POP;
					end
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						unw_q   <= '0;
						state_q <= ST_UNWIND;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					head_q <= head_q + POS_W'(1);
					// first entry of the next level: the queue tail now ends that level
					if (head_q == lvl_end_q) begin
						lvl_q     <= child_lvl;
						lvl_end_q <= tail_q;
					end
					k_q     <= '0;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (nb_free && !nb_hit) begin
						tail_q <= tail_q + POS_W'(1);
					end
					if (nb_hit) begin
						found_q <= 1'b1;
						unw_q   <= '0;
						state_q <= ST_UNWIND;
					end else if (k_q == K_DRAIN) begin
						state_q <= ST_POP;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_UNWIND: begin
					if (unw_q != tail_q) begin
						unw_q <= unw_q + POS_W'(1);
					end else if (!unw_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						found_q      <= 1'b0;
						load_pos_q   <= '0;
						start_pres_q <= 1'b0;
						end_pres_q   <= 1'b0;
						start_pos_q  <= '0;
						end_pos_q    <= '0;
						state_q      <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		nb_ent_s1 <= nb_ent;
		if (state_q == ST_FETCH) begin
			here_q <= q_rdata;
		end
		if (nb_hit) begin
			dist_q <= child_lvl;
		end
		if (res_load) begin
			result_q <= found_q ? '{distance: dist_q, unreachable: 1'b0}
				: '{distance: '0, unreachable: 1'b1};
		end
	end

	// wall and visited bit per cell
	gbsp_ram #(
		.WIDTH ($bits(cell_entry_t)),
		.DEPTH (CELLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rd)
	);

	// frontier queue, also the list of cells to unmark afterwards
	gbsp_ram #(
		.WIDTH ($bits(qent_t)),
		.DEPTH (CELLS)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	gbsp_div #(
		.DW (AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (start_pos_q),
		.divisor  (eff_cols),
		.res      (div_res)
	);

endmodule
`default_nettype wire

// ----- rtl/gbsp_checker.sv -----
// port-level checker for the grid search block and its bind
`timescale 1ns / 1ps
`default_nettype none
module gbsp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cell_valid,
	input logic                       cell_stall,
	input gbsp_pkg::cell_item_t       cell_item,
	input logic                       result_valid,
	input logic                       result_stall,
	input gbsp_pkg::result_item_t     result
);
	import gbsp_pkg::*;

	logic [1:0] pend_q;
	logic       last_acc;
	logic       res_acc;

	assign last_acc = cell_valid && !cell_stall && cell_item.last_cell;
	assign res_acc  = result_valid && !result_stall;

	// grids whose last item went in and whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (last_acc && !res_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (res_acc && !last_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result item changed");

	a_distance_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.unreachable && result.distance == '0)
			|| (!result.unreachable && result.distance != '0))
		else $error("distance does not match unreachable flag");

	a_search_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		last_acc |=> cell_stall)
		else $error("input taken right after the last cell");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result item without a finished grid");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two grids outstanding");

endmodule

bind grid_bfs_shortest_path gbsp_checker u_gbsp_checker (.*);
`default_nettype wire
